// ----- rtl/core/ksd_pkg.sv -----
// ----------------------------------------------------------------------------
// ksd_pkg
// Shared types, class codes and pattern constants of the key sequence
// shortcut decoder.
// ----------------------------------------------------------------------------
package ksd_pkg;

    localparam int MAX_SEQ_LEN = 6;
    localparam int NUM_CFG     = 7;
    localparam int NUM_FIXED   = 3;
    localparam int NUM_PAT     = NUM_CFG + NUM_FIXED;
    localparam int SEQ_W       = 51;
    localparam int CFG_IDX_W   = 3;
    localparam int CLASS_W     = 4;
    localparam int HELD_W      = 3;
    localparam int OUT_DATA_W  = 16;

    typedef logic [SEQ_W-1:0]   t_seq_word;
    typedef logic [NUM_PAT-1:0] t_live;
    typedef logic [HELD_W-1:0]  t_held;
    typedef logic [CLASS_W-1:0] t_key_class;

    // result classes
    localparam t_key_class CLS_LITERAL    = 4'd0;
    localparam t_key_class CLS_PENDING    = 4'd1;
    localparam t_key_class CLS_SHORT_BASE = 4'd2;
    localparam t_key_class CLS_ENTER      = 4'd12;
    localparam t_key_class CLS_BACKSPACE  = 4'd13;

    localparam logic [7:0] KEY_ENTER = 8'h0A;
    localparam logic [7:0] KEY_BKSP  = 8'h7F;
    localparam logic [7:0] KEY_NUL   = 8'h00;

    localparam t_live ALL_LIVE = '1;

    // bytes low first in 47:0, length in 50:48
    localparam t_seq_word CFG_RESET [NUM_CFG] = '{
        51'h1_0000_0000_0001,   // line start: ^A
        51'h1_0000_0000_0005,   // line end: ^E
        51'h6_4335_3B31_5B1B,   // next word: ESC [ 1 ; 5 C
        51'h6_4435_3B31_5B1B,   // prev word: ESC [ 1 ; 5 D
        51'h1_0000_0000_0009,   // complete: TAB
        51'h3_0000_0041_5B1B,   // history back: ESC [ A
        51'h3_0000_0042_5B1B    // history fwd: ESC [ B
    };

    localparam t_seq_word FIXED_PATS [NUM_FIXED] = '{
        51'h3_0000_0043_5B1B,   // right: ESC [ C
        51'h3_0000_0044_5B1B,   // left: ESC [ D
        51'h4_0000_7E33_5B1B    // delete: ESC [ 3 ~
    };

    typedef struct packed {
        t_key_class key_class;
        t_live      next_live;
        t_held      next_held;
    } t_match_res;

endpackage

// ----- rtl/core/key_sequence_shortcut_decoder_core.sv -----
// ----------------------------------------------------------------------------
// key_sequence_shortcut_decoder_core
// Keystroke decoder: matches raw key bytes against seven programmable
// shortcut sequences and three fixed escape sequences.
//
//  channel  | dir | payload
//  ---------+-----+----------------------------------------------
//  s_*      | in  | tdata[7:0] key_byte
//  m_*      | out | tdata[3:0] key_class, [11:4] literal_byte
//  cfg_*    | in  | idx 0..6 shortcut sequence, wdata 51 bits
//
//  One item per cycle while results are taken; the accepting edge loads the
//  input register and the result register is loaded from it once free, so a
//  result follows its item through both registers, match state updated with it.
//  Throughput is limited only by the result register: a stalled result
//  holds the input register, and o_s_tready drops once both are full.
//  Synchronous active-low reset clears match state and reloads the
//  default sequences.
// ----------------------------------------------------------------------------
module key_sequence_shortcut_decoder_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [7:0]                       i_s_tdata,   // [7:0] key_byte
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [ksd_pkg::OUT_DATA_W-1:0]   o_m_tdata,   // [3:0] key_class,
                                                          // [11:4] literal_byte
    input  logic                             i_cfg_we,
    input  logic [ksd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ksd_pkg::SEQ_W-1:0]        i_cfg_wdata
);
    import ksd_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;
    t_live      r_live;
    t_held      r_held;
    t_seq_word  r_cfg [NUM_CFG];

    t_seq_word  pats [NUM_PAT];
    t_match_res mres;
    logic       out_free;
    logic       advance;
    logic [7:0] lit;

    assign out_free   = !r_out_vld || i_m_tready;
    assign advance    = r_in_vld && out_free;
    assign o_s_tready = !r_in_vld || out_free;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        for (int p = 0; p < NUM_CFG; p++) begin
            pats[p] = r_cfg[p];
        end
        for (int f = 0; f < NUM_FIXED; f++) begin
            pats[NUM_CFG + f] = FIXED_PATS[f];
        end
    end

    ksd_match u_match (
        .i_key_byte (r_in_byte),
        .i_live     (r_live),
        .i_held     (r_held),
        .i_pats     (pats),
        .o_res      (mres)
    );

    assign lit = (mres.key_class == CLS_LITERAL) ? r_in_byte : 8'h00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_live    <= ALL_LIVE;
            r_held    <= '0;
            for (int p = 0; p < NUM_CFG; p++) begin
                r_cfg[p] <= CFG_RESET[p];
            end
        end else begin
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (advance) begin
                r_live <= mres.next_live;
                r_held <= mres.next_held;
            end
            if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_CFG))) begin
                r_cfg[i_cfg_idx] <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        if (advance) begin
            r_out_data <= {(OUT_DATA_W - CLASS_W - 8)'(0), lit, mres.key_class};
        end
    end

    // a partial match never runs past the longest sequence
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held < HELD_W'(MAX_SEQ_LEN))
        else $error("held count out of range");

    // bytes held implies at least one live pattern
    a_held_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != '0) |-> (r_live != '0))
        else $error("held bytes with no live pattern");

    // literal byte only carried on literal results
    a_lit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_data[CLASS_W+7:CLASS_W] != 8'h00))
        |-> (r_out_data[CLASS_W-1:0] == CLS_LITERAL))
        else $error("literal byte on non-literal class");

    // taking an item while full requires the pending one to move on
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && r_in_vld) |-> out_free)
        else $error("input register overrun");

    // match state only changes when an item is decoded
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_live) && $stable(r_held)))
        else $error("match state changed without an item");

endmodule

// ----- rtl/core/ksd_match.sv -----
// ----------------------------------------------------------------------------
// ksd_match
// Per-byte pattern compare, first-match pick and next match state.
// ----------------------------------------------------------------------------
module ksd_match (
    input  logic [7:0]          i_key_byte,
    input  ksd_pkg::t_live      i_live,
    input  ksd_pkg::t_held      i_held,
    input  ksd_pkg::t_seq_word  i_pats [ksd_pkg::NUM_PAT],
    output ksd_pkg::t_match_res o_res
);
    import ksd_pkg::*;

    t_live      hit;
    t_live      done;
    logic       any_done;
    t_key_class done_class;
    logic       special;

    function automatic logic [7:0] seq_byte(input t_seq_word w, input t_held n);
        logic [7:0] b;
        case (n)
            3'd0:    b = w[7:0];
            3'd1:    b = w[15:8];
            3'd2:    b = w[23:16];
            3'd3:    b = w[31:24];
            3'd4:    b = w[39:32];
            3'd5:    b = w[47:40];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    assign special = (i_key_byte == KEY_NUL) || (i_key_byte == KEY_ENTER)
                   || (i_key_byte == KEY_BKSP);

    always_comb begin
        logic [2:0] len;
        logic       en;
        for (int p = 0; p < NUM_PAT; p++) begin
            len     = i_pats[p][SEQ_W-1:48];
            en      = (len != 3'd0) && (len <= 3'(MAX_SEQ_LEN));
            hit[p]  = !special && en && i_live[p] && (i_held < len)
                    && (seq_byte(i_pats[p], i_held) == i_key_byte);
            done[p] = hit[p] && (({1'b0, i_held} + 4'd1) == {1'b0, len});
        end
    end

    // first pattern in list order wins
    always_comb begin
        any_done   = 1'b0;
        done_class = CLS_LITERAL;
        for (int p = NUM_PAT - 1; p >= 0; p--) begin
            if (done[p]) begin
                any_done   = 1'b1;
                done_class = CLS_SHORT_BASE + CLASS_W'(p);
            end
        end
    end

    always_comb begin
        o_res.key_class = CLS_LITERAL;
        o_res.next_live = ALL_LIVE;
        o_res.next_held = '0;
        if (i_key_byte == KEY_ENTER) begin
            o_res.key_class = CLS_ENTER;
        end else if (i_key_byte == KEY_BKSP) begin
            o_res.key_class = CLS_BACKSPACE;
            o_res.next_live = i_live;
            o_res.next_held = i_held;
        end else if (any_done) begin
            o_res.key_class = done_class;
        end else if (hit != '0) begin
            o_res.key_class = CLS_PENDING;
            o_res.next_live = hit;
            o_res.next_held = i_held + 3'd1;
        end
    end

endmodule
